/* rtl/core/gssc_pkg.sv */
// ----------------------------------------------------------------------------
// gssc_pkg
// shared types, constants and the step program of the scheduled controller
// ----------------------------------------------------------------------------
package gssc_pkg;

	localparam int MAX_STATES = 8;
	localparam int MAX_TERMS  = 4;

	localparam int IDX_W   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int ROW_W   = $clog2(MAX_STATES + 1);
	localparam int TERM_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int A_DEPTH = MAX_STATES * MAX_TERMS;
	localparam int B_DEPTH = (MAX_STATES + 1) * MAX_TERMS;
	localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int B_AW    = $clog2(B_DEPTH);
	localparam int TCNT_W  = $clog2(MAX_TERMS + 1);

	localparam int PROG_LEN = 19;
	localparam int PC_W     = $clog2(PROG_LEN);

	// configuration register indexes
	localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
	localparam logic [1:0] REG_STATE_COUNT = 2'd1;
	localparam logic [1:0] REG_TERM_COUNT  = 2'd2;

	// stage weights, unsigned Q0.16
	localparam logic [15:0] W_HALF = 16'd32768;
	localparam logic [15:0] W_3Q   = 16'd49152;
	localparam logic [15:0] W_2_9  = 16'd14564;
	localparam logic [15:0] W_1_3  = 16'd21845;
	localparam logic [15:0] W_4_9  = 16'd29127;
	localparam logic [15:0] W_7_24 = 16'd19115;
	localparam logic [15:0] W_1_4  = 16'd16384;
	localparam logic [15:0] W_1_8  = 16'd8192;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		CMD_STEP  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		OP_SCHED,
		OP_COPY,
		OP_DERIV,
		OP_AXPY,
		OP_DRIVE
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROG,
		ST_RD,
		ST_HLOAD,
		ST_ISSUE,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] w;
		logic [1:0]  kidx;
		logic        to_x;
	} instr_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} mac_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
		logic        clip;
	} mac_rsp_t;

	// one control step: schedule, three stage points, fourth slope, update, drive
	function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
		instr_t r;
		r = '{op: OP_COPY, w: 16'd0, kidx: 2'd0, to_x: 1'b0};
		unique case (pc)
			5'd0:  r = '{op: OP_SCHED, w: 16'd0,  kidx: 2'd0, to_x: 1'b0};
			5'd1:  r = '{op: OP_COPY,  w: 16'd0,  kidx: 2'd0, to_x: 1'b0};
			5'd2:  r = '{op: OP_DERIV, w: 16'd0,  kidx: 2'd0, to_x: 1'b0};
			5'd3:  r = '{op: OP_COPY,  w: 16'd0,  kidx: 2'd0, to_x: 1'b0};
			5'd4:  r = '{op: OP_AXPY,  w: W_HALF, kidx: 2'd0, to_x: 1'b0};
			5'd5:  r = '{op: OP_DERIV, w: 16'd0,  kidx: 2'd1, to_x: 1'b0};
			5'd6:  r = '{op: OP_COPY,  w: 16'd0,  kidx: 2'd0, to_x: 1'b0};
			5'd7:  r = '{op: OP_AXPY,  w: W_3Q,   kidx: 2'd1, to_x: 1'b0};
			5'd8:  r = '{op: OP_DERIV, w: 16'd0,  kidx: 2'd2, to_x: 1'b0};
			5'd9:  r = '{op: OP_COPY,  w: 16'd0,  kidx: 2'd0, to_x: 1'b0};
			5'd10: r = '{op: OP_AXPY,  w: W_2_9,  kidx: 2'd0, to_x: 1'b0};
			5'd11: r = '{op: OP_AXPY,  w: W_1_3,  kidx: 2'd1, to_x: 1'b0};
			5'd12: r = '{op: OP_AXPY,  w: W_4_9,  kidx: 2'd2, to_x: 1'b0};
			5'd13: r = '{op: OP_DERIV, w: 16'd0,  kidx: 2'd3, to_x: 1'b0};
			5'd14: r = '{op: OP_AXPY,  w: W_7_24, kidx: 2'd0, to_x: 1'b1};
			5'd15: r = '{op: OP_AXPY,  w: W_1_4,  kidx: 2'd1, to_x: 1'b1};
			5'd16: r = '{op: OP_AXPY,  w: W_1_3,  kidx: 2'd2, to_x: 1'b1};
			5'd17: r = '{op: OP_AXPY,  w: W_1_8,  kidx: 2'd3, to_x: 1'b1};
			5'd18: r = '{op: OP_DRIVE, w: 16'd0,  kidx: 2'd0, to_x: 1'b0};
			default: r = '{op: OP_COPY, w: 16'd0, kidx: 2'd0, to_x: 1'b0};
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/gssc_mac.sv */
// ----------------------------------------------------------------------------
// gssc_mac
// shared Q16.16 multiply-accumulate: res = sat(c + sat(floor(a*b >> 16)))
// ----------------------------------------------------------------------------
module gssc_mac import gssc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_req_t req,
	output mac_rsp_t rsp
);

	logic signed [63:0] prod_s1;
	logic        [31:0] c_s1;
	logic               v_s1;
	logic        [31:0] res_s2;
	logic               clip_s2;
	logic               v_s2;

	logic        [47:0] p48;
	logic               ovf_mul;
	logic        [31:0] m;
	logic        [32:0] sum;
	logic               ovf_add;
	logic        [31:0] r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(req.a) * $signed(req.b);
		c_s1    <= req.c;
		res_s2  <= r;
		clip_s2 <= ovf_mul | ovf_add;
	end

	always_comb begin
		// dropping the low bits of a two's complement value floors it
		p48     = prod_s1[63:16];
		ovf_mul = !((&p48[47:31]) || !(|p48[47:31]));
		m       = ovf_mul ? (p48[47] ? Q_MIN : Q_MAX) : p48[31:0];
		sum     = {c_s1[31], c_s1} + {m[31], m};
		ovf_add = sum[32] ^ sum[31];
		r       = ovf_add ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];
	end

	assign rsp.done = v_s2;
	assign rsp.res  = res_s2;
	assign rsp.clip = clip_s2;

endmodule

/* rtl/core/gain_scheduled_state_controller_core.sv */
// ----------------------------------------------------------------------------
// gain_scheduled_state_controller_core
// step item: Horner terms and state multiply-accumulates all run one at a time
// on the single shared two-stage MAC. write and clear items are taken only
// while idle; no new item while a step runs.
// reset clears tables (per-entry valid bits) and plant state and sets registers to defaults at once.
// ----------------------------------------------------------------------------
module gain_scheduled_state_controller_core import gssc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// error_value, speed_value, row_index, term_index, coef_value, zero pad
	input  logic [103:0] s_tdata,
	// cmd, table_select
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// drive_command
	output logic [31:0]  m_tdata,
	// saturated
	output logic [0:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata
);

	state_t state_q, state_d;

	logic [PC_W-1:0]  pc_q;
	logic [15:0]      h_q;
	logic [3:0]       nreg_q;
	logic [2:0]       treg_q;
	logic             clip_q;
	logic [IDX_W-1:0] i_q;
	logic [ROW_W-1:0] r_q;
	logic [TERM_W-1:0] j_q;
	logic             tsel_q;
	logic             first_q;
	logic [A_DEPTH-1:0] va_q;
	logic [B_DEPTH-1:0] vb_q;
	logic [31:0]      x_q [MAX_STATES];

	logic [31:0] ta_mem [A_DEPTH];
	logic [31:0] tb_mem [B_DEPTH];
	logic [31:0] rd_q;
	logic [31:0] e_q;
	logic [31:0] s_q;
	logic [31:0] acc_q;
	logic [15:0] f_q;
	logic [31:0] y_q  [MAX_STATES];
	logic [31:0] k_q  [4][MAX_STATES];
	logic [31:0] sa_q [MAX_STATES];
	logic [31:0] sb_q [MAX_STATES + 1];

	cmd_t        in_cmd;
	logic        in_tsel;
	logic [3:0]  in_row;
	logic [1:0]  in_term;
	logic        take;
	logic        wr_a;
	logic        wr_b;
	logic [A_AW-1:0] wa_addr;
	logic [B_AW-1:0] wb_addr;

	instr_t ins;
	logic [ROW_W-1:0]  n_eff;
	logic [IDX_W-1:0]  n_m1;
	logic [TCNT_W-1:0] t_eff;
	logic [TERM_W-1:0] t_m1;
	logic              last_i;
	logic              sched_done_row;
	logic              a_last_row;
	logic              sched_step;
	logic [31:0]       sched_v;
	logic [A_AW-1:0]   ra_addr;
	logic [B_AW-1:0]   rb_addr;
	logic [ROW_W-1:0]  sb_idx;
	logic [31:0]       dst_i;
	logic              mac_fin;

	mac_req_t mreq;
	mac_rsp_t mrsp;

	gssc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign in_cmd  = cmd_t'(s_tuser[1:0]);
	assign in_tsel = s_tuser[2];
	assign in_row  = s_tdata[67:64];
	assign in_term = s_tdata[69:68];
	assign take    = s_tvalid && s_tready;
	assign wr_a    = take && in_cmd == CMD_WRITE && !in_tsel
		&& int'(in_row) < MAX_STATES && int'(in_term) < MAX_TERMS;
	assign wr_b    = take && in_cmd == CMD_WRITE && in_tsel
		&& int'(in_row) <= MAX_STATES && int'(in_term) < MAX_TERMS;
	assign wa_addr = A_AW'(int'(in_row) * MAX_TERMS + int'(in_term));
	assign wb_addr = B_AW'(int'(in_row) * MAX_TERMS + int'(in_term));

	assign ins = prog_rom(pc_q);

	always_comb begin
		if (nreg_q == 4'd0) begin
			n_eff = ROW_W'(1);
		end else if (int'(nreg_q) > MAX_STATES) begin
			n_eff = ROW_W'(MAX_STATES);
		end else begin
			n_eff = ROW_W'(nreg_q);
		end
		if (treg_q == 3'd0) begin
			t_eff = TCNT_W'(1);
		end else if (int'(treg_q) > MAX_TERMS) begin
			t_eff = TCNT_W'(MAX_TERMS);
		end else begin
			t_eff = TCNT_W'(treg_q);
		end
	end

	assign n_m1           = IDX_W'(n_eff - 1'b1);
	assign t_m1           = TERM_W'(t_eff - 1'b1);
	assign last_i         = (i_q == n_m1);
	assign sched_done_row = tsel_q && (r_q == n_eff);
	assign a_last_row     = !tsel_q && (r_q == ROW_W'(n_eff - 1'b1));
	assign mac_fin        = (state_q == ST_WAIT) && mrsp.done;
	assign sched_step     = (state_q == ST_HLOAD) || (mac_fin && ins.op == OP_SCHED);
	assign sched_v        = (state_q == ST_HLOAD) ? rd_q : mrsp.res;
	assign ra_addr        = A_AW'(int'(r_q) * MAX_TERMS + int'(j_q));
	assign rb_addr        = B_AW'(int'(r_q) * MAX_TERMS + int'(j_q));
	assign sb_idx         = first_q ? n_eff : ROW_W'(i_q);
	assign dst_i          = ins.to_x ? x_q[i_q] : y_q[i_q];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && in_cmd == CMD_STEP) state_d = ST_PROG;
			end
			ST_PROG: begin
				unique case (ins.op)
					OP_SCHED: state_d = ST_RD;
					OP_COPY:  state_d = ST_PROG;
					default:  state_d = ST_ISSUE;
				endcase
			end
			ST_RD: state_d = first_q ? ST_HLOAD : ST_ISSUE;
			ST_HLOAD: begin
				state_d = (j_q == '0 && sched_done_row) ? ST_PROG : ST_RD;
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (mrsp.done) begin
					unique case (ins.op)
						OP_SCHED: state_d = (j_q == '0 && sched_done_row) ? ST_PROG : ST_RD;
						OP_DERIV: state_d = last_i ? ST_PROG : ST_ISSUE;
						OP_AXPY:  state_d = (!first_q && last_i) ? ST_PROG : ST_ISSUE;
						OP_DRIVE: state_d = (!first_q && last_i) ? ST_OUT : ST_ISSUE;
						default:  state_d = ST_PROG;
					endcase
				end
			end
			ST_OUT: begin
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and MAC operands
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		m_tvalid   = (state_q == ST_OUT);
		m_tdata    = acc_q;
		m_tuser    = clip_q;
		mreq.start = (state_q == ST_ISSUE);
		mreq.a     = acc_q;
		mreq.b     = s_q;
		mreq.c     = rd_q;
		case (ins.op)
			OP_DERIV: begin
				mreq.a = sa_q[i_q];
				mreq.b = y_q[i_q];
				mreq.c = acc_q;
			end
			OP_AXPY: begin
				if (first_q) begin
					// step factor w*h, never clips
					mreq.a = {16'd0, ins.w};
					mreq.b = {16'd0, h_q};
					mreq.c = '0;
				end else begin
					mreq.a = {16'd0, f_q};
					mreq.b = k_q[ins.kidx][i_q];
					mreq.c = dst_i;
				end
			end
			OP_DRIVE: begin
				mreq.a = sb_q[sb_idx];
				mreq.b = first_q ? e_q : x_q[i_q];
				mreq.c = first_q ? 32'd0 : acc_q;
			end
			default: begin
				mreq.a = acc_q;
				mreq.b = s_q;
				mreq.c = rd_q;
			end
		endcase
	end

	// control registers and plant state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			h_q     <= 16'd655;
			nreg_q  <= 4'd1;
			treg_q  <= 3'd1;
			clip_q  <= 1'b0;
			i_q     <= '0;
			r_q     <= '0;
			j_q     <= '0;
			tsel_q  <= 1'b0;
			first_q <= 1'b0;
			va_q    <= '0;
			vb_q    <= '0;
			for (int m = 0; m < MAX_STATES; m++) x_q[m] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_STEP_SIZE:   h_q    <= cfg_wdata;
					REG_STATE_COUNT: nreg_q <= cfg_wdata[3:0];
					REG_TERM_COUNT:  treg_q <= cfg_wdata[2:0];
					default: ;
				endcase
			end
			if (wr_a) va_q[wa_addr] <= 1'b1;
			if (wr_b) vb_q[wb_addr] <= 1'b1;
			if (take && in_cmd == CMD_CLEAR) begin
				for (int m = 0; m < MAX_STATES; m++) x_q[m] <= '0;
			end
			if (take && in_cmd == CMD_STEP) begin
				pc_q   <= '0;
				clip_q <= 1'b0;
			end
			if (state_q == ST_PROG) begin
				case (ins.op)
					OP_SCHED: begin
						tsel_q  <= 1'b0;
						r_q     <= '0;
						j_q     <= t_m1;
						first_q <= 1'b1;
					end
					OP_COPY:  pc_q <= pc_q + 1'b1;
					OP_DERIV: i_q  <= '0;
					default: begin
						i_q     <= '0;
						first_q <= 1'b1;
					end
				endcase
			end
			if (state_q == ST_HLOAD) first_q <= 1'b0;
			if (mac_fin) begin
				clip_q <= clip_q | mrsp.clip;
				case (ins.op)
					OP_DERIV: begin
						if (last_i) pc_q <= pc_q + 1'b1;
						else i_q <= i_q + 1'b1;
					end
					OP_AXPY: begin
						if (first_q) begin
							first_q <= 1'b0;
						end else begin
							if (ins.to_x) x_q[i_q] <= mrsp.res;
							if (last_i) pc_q <= pc_q + 1'b1;
							else i_q <= i_q + 1'b1;
						end
					end
					OP_DRIVE: begin
						if (first_q) first_q <= 1'b0;
						else if (!last_i) i_q <= i_q + 1'b1;
					end
					default: ;
				endcase
			end
			// horner term done: next term, next row, next table or end of the schedule
			if (sched_step) begin
				if (j_q == '0) begin
					first_q <= 1'b1;
					j_q     <= t_m1;
					if (sched_done_row) begin
						pc_q <= pc_q + 1'b1;
					end else if (a_last_row) begin
						tsel_q <= 1'b1;
						r_q    <= '0;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end else begin
					j_q <= j_q - 1'b1;
				end
			end
		end
	end

	// coefficient tables and work values
	always_ff @(posedge clk) begin
		if (wr_a) ta_mem[wa_addr] <= s_tdata[101:70];
		if (wr_b) tb_mem[wb_addr] <= s_tdata[101:70];
		if (tsel_q) rd_q <= vb_q[rb_addr] ? tb_mem[rb_addr] : 32'd0;
		else        rd_q <= va_q[ra_addr] ? ta_mem[ra_addr] : 32'd0;
		if (take && in_cmd == CMD_STEP) begin
			e_q <= s_tdata[31:0];
			s_q <= s_tdata[63:32];
		end
		if (state_q == ST_PROG) begin
			if (ins.op == OP_DERIV) acc_q <= e_q;
			if (ins.op == OP_COPY) begin
				for (int m = 0; m < MAX_STATES; m++) y_q[m] <= x_q[m];
			end
		end
		if (state_q == ST_HLOAD) acc_q <= rd_q;
		if (sched_step && j_q == '0) begin
			if (tsel_q) sb_q[r_q] <= sched_v;
			else        sa_q[r_q[IDX_W-1:0]] <= sched_v;
		end
		if (mac_fin) begin
			case (ins.op)
				OP_SCHED, OP_DRIVE: acc_q <= mrsp.res;
				OP_DERIV: begin
					acc_q <= mrsp.res;
					if (last_i) begin
						// companion form: slope of state m is state m-1
						k_q[ins.kidx][0] <= mrsp.res;
						for (int m = 1; m < MAX_STATES; m++) k_q[ins.kidx][m] <= y_q[m-1];
					end
				end
				OP_AXPY: begin
					if (first_q) f_q <= mrsp.res[15:0];
					else if (!ins.to_x) y_q[i_q] <= mrsp.res;
				end
				default: ;
			endcase
		end
	end

endmodule

/* verif/gain_scheduled_state_controller_core_tb.sv */
// ----------------------------------------------------------------------------
// gain_scheduled_state_controller_core_tb
// the stimulus is coefficient writes, state clears, unknown commands and control steps.
// a local fixed-point model of the scheduled rk23 controller predicts each
// drive command and its saturation flag. the run covers several register
// settings and several idle and stall patterns on both stream sides.
// ----------------------------------------------------------------------------
module gain_scheduled_state_controller_core_tb;
	import gssc_pkg::*;

	typedef logic signed [31:0] q_t;
	typedef q_t qvec_t [MAX_STATES];

	typedef struct {
		q_t   drive;
		logic sat;
	} drive_t;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_we;
	logic [1:0]   cfg_addr;
	logic [15:0]  cfg_wdata;

	gain_scheduled_state_controller_core DUT (.*);

	// controller model state
	q_t          coef_a [MAX_STATES*MAX_TERMS];
	q_t          coef_b [(MAX_STATES+1)*MAX_TERMS];
	qvec_t       plant_x;
	q_t          gain_a [MAX_STATES];
	q_t          gain_b [MAX_STATES+1];
	logic [15:0] h_reg;
	logic [3:0]  n_reg;
	logic [2:0]  t_reg;
	logic        clipped;
	int unsigned n_use;

	drive_t pending_drive[$];
	int     fail_count;
	int     send_idle_pct;
	int     recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic q_t sat32(longint v);
		if (v > longint'(Q_MAX)) begin
			clipped = 1'b1;
			return Q_MAX;
		end
		if (v < longint'(Q_MIN)) begin
			clipped = 1'b1;
			return Q_MIN;
		end
		return q_t'(v);
	endfunction

	function automatic q_t qmul(q_t a, q_t b);
		longint p;
		p = longint'(a) * longint'(b);
		return sat32(p >>> 16);
	endfunction

	function automatic q_t qadd(q_t a, q_t b);
		return sat32(longint'(a) + longint'(b));
	endfunction

	function automatic q_t horner_eval(bit use_b, int unsigned row, int unsigned t, q_t s);
		q_t y;
		int unsigned base;
		base = row * MAX_TERMS;
		y = use_b ? coef_b[base + t - 1] : coef_a[base + t - 1];
		for (int i = int'(t) - 1; i > 0; i--)
			y = qadd(qmul(y, s), use_b ? coef_b[base + i - 1] : coef_a[base + i - 1]);
		return y;
	endfunction

	function automatic qvec_t slope(q_t e, qvec_t x);
		qvec_t k;
		q_t acc;
		k = x;
		acc = e;
		for (int i = 0; i < n_use; i++)
			acc = qadd(acc, qmul(gain_a[i], x[i]));
		for (int i = int'(n_use) - 1; i > 0; i--)
			k[i] = x[i-1];
		k[0] = acc;
		return k;
	endfunction

	function automatic qvec_t axpy(logic [15:0] w, qvec_t k, qvec_t x);
		q_t f;
		f = q_t'((longint'(w) * longint'(h_reg)) >> 16);
		for (int i = 0; i < n_use; i++)
			x[i] = qadd(x[i], qmul(f, k[i]));
		return x;
	endfunction

	function automatic drive_t controller_step(q_t e, q_t s);
		qvec_t k0, k1, k2, k3, p;
		int unsigned t;
		drive_t r;
		n_use = (n_reg < 1) ? 1 : (n_reg > MAX_STATES) ? MAX_STATES : n_reg;
		t = (t_reg < 1) ? 1 : (t_reg > MAX_TERMS) ? MAX_TERMS : t_reg;
		clipped = 1'b0;
		for (int i = 0; i < n_use; i++)
			gain_a[i] = horner_eval(1'b0, i, t, s);
		for (int i = 0; i <= n_use; i++)
			gain_b[i] = horner_eval(1'b1, i, t, s);
		k0 = slope(e, plant_x);
		p  = axpy(W_HALF, k0, plant_x);
		k1 = slope(e, p);
		p  = axpy(W_3Q, k1, plant_x);
		k2 = slope(e, p);
		p  = axpy(W_2_9, k0, plant_x);
		p  = axpy(W_1_3, k1, p);
		p  = axpy(W_4_9, k2, p);
		k3 = slope(e, p);
		plant_x = axpy(W_7_24, k0, plant_x);
		plant_x = axpy(W_1_4, k1, plant_x);
		plant_x = axpy(W_1_3, k2, plant_x);
		plant_x = axpy(W_1_8, k3, plant_x);
		r.drive = qmul(gain_b[n_use], e);
		for (int i = 0; i < n_use; i++)
			r.drive = qadd(r.drive, qmul(gain_b[i], plant_x[i]));
		r.sat = clipped;
		return r;
	endfunction

	// applies one accepted item to the model
	function automatic void apply_item(logic [1:0] cmd, q_t e, q_t s, logic tsel,
			logic [3:0] row, logic [1:0] term, q_t coef);
		if (cmd == CMD_WRITE) begin
			if (!tsel && row < MAX_STATES)
				coef_a[row*MAX_TERMS + term] = coef;
			else if (tsel && row <= MAX_STATES)
				coef_b[row*MAX_TERMS + term] = coef;
		end else if (cmd == CMD_CLEAR) begin
			foreach (plant_x[i]) plant_x[i] = '0;
		end else if (cmd == CMD_STEP) begin
			pending_drive = {pending_drive, controller_step(e, s)};
		end
	endfunction

	task automatic send_item(logic [1:0] cmd, q_t e, q_t s, logic tsel,
			logic [3:0] row, logic [1:0] term, q_t coef);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = {2'b00, coef, term, row, s, e};
		s_tuser  = {tsel, cmd};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		apply_item(cmd, e, s, tsel, row, term, coef);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_drive.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		wait_drained();
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_STEP_SIZE:   h_reg = val;
			REG_STATE_COUNT: n_reg = val[3:0];
			REG_TERM_COUNT:  t_reg = val[2:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] h, logic [3:0] n, logic [2:0] t);
		write_reg(REG_STEP_SIZE, h);
		write_reg(REG_STATE_COUNT, {12'd0, n});
		write_reg(REG_TERM_COUNT, {13'd0, t});
	endtask

	// mostly modest magnitudes so that steps do not all saturate
	function automatic q_t rand_q();
		q_t v;
		v = $urandom;
		if ($urandom_range(7) == 0)
			return v;
		return v >>> $urandom_range(20, 8);
	endfunction

	task automatic send_random();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			send_item(CMD_STEP, rand_q(), rand_q(), 1'b0, 4'd0, 2'd0, 32'sd0);
		else if (r < 90)
			send_item(CMD_WRITE, $urandom, $urandom, 1'($urandom),
				4'($urandom_range(9)), 2'($urandom), rand_q());
		else if (r < 95)
			send_item(CMD_CLEAR, $urandom, $urandom, 1'($urandom), 4'($urandom),
				2'($urandom), $urandom);
		else
			send_item(CMD_UNKNOWN, $urandom, $urandom, 1'($urandom), 4'($urandom),
				2'($urandom), $urandom);
	endtask

	task automatic test_directed();
		set_config(16'd65535, 4'd2, 3'd2);
		send_item(CMD_WRITE, 0, 0, 1'b0, 4'd0, 2'd0, 32'sh0000_8000);
		send_item(CMD_WRITE, 0, 0, 1'b0, 4'd1, 2'd1, 32'shffff_0000);
		send_item(CMD_WRITE, 0, 0, 1'b1, 4'd0, 2'd0, 32'sh0001_0000);
		send_item(CMD_WRITE, 0, 0, 1'b1, 4'd2, 2'd1, 32'sh0000_4000);
		// rows past the end of each table are dropped; the last row of table B is kept
		send_item(CMD_WRITE, 0, 0, 1'b0, 4'd8, 2'd3, Q_MAX);
		send_item(CMD_WRITE, 0, 0, 1'b1, 4'd9, 2'd3, Q_MIN);
		send_item(CMD_WRITE, 0, 0, 1'b1, 4'd15, 2'd2, Q_MAX);
		send_item(CMD_WRITE, 0, 0, 1'b1, 4'd8, 2'd3, Q_MIN);
		send_item(CMD_STEP, 32'sh0001_0000, 32'sh0000_8000, 1'b0, 4'd0, 2'd0, 0);
		send_item(CMD_STEP, Q_MAX, Q_MAX, 1'b1, 4'd15, 2'd3, Q_MAX);
		send_item(CMD_STEP, Q_MIN, Q_MIN, 1'b0, 4'd0, 2'd0, Q_MIN);
		send_item(CMD_UNKNOWN, Q_MAX, Q_MAX, 1'b1, 4'd15, 2'd3, Q_MAX);
		send_item(CMD_STEP, 32'sh0000_0001, -32'sh0000_0001, 1'b0, 4'd0, 2'd0, 0);
		send_item(CMD_CLEAR, 0, 0, 1'b0, 4'd0, 2'd0, 0);
		send_item(CMD_STEP, -32'sh0002_0000, 0, 1'b0, 4'd0, 2'd0, 0);
		// shrink the state count, then grow it so hidden states come back
		set_config(16'd0, 4'd0, 3'd0);
		send_item(CMD_STEP, 32'sh0003_0000, 32'sh0001_0000, 1'b0, 4'd0, 2'd0, 0);
		set_config(16'd40000, 4'd15, 3'd7);
		send_item(CMD_STEP, 32'sh0003_0000, 32'sh0001_0000, 1'b0, 4'd0, 2'd0, 0);
		send_item(CMD_STEP, 0, Q_MAX, 1'b0, 4'd0, 2'd0, 0);
	endtask

	task automatic test_drained_steps();
		for (int i = 0; i < 4; i++) begin
			send_item(CMD_STEP, rand_q(), rand_q(), 1'b0, 4'd0, 2'd0, 0);
			wait_drained();
		end
	endtask

	task automatic test_random_phases();
		int idle_set [4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{19, 19}};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_set[ph][0];
			recv_stall_pct = idle_set[ph][1];
			for (int c = 0; c < 3; c++) begin
				if (ph == 0 && c == 0)
					set_config(16'd65535, 4'd8, 3'd4);
				else if (ph == 0 && c == 1)
					set_config(16'd0, 4'd1, 3'd1);
				else
					set_config(16'($urandom), 4'($urandom), 3'($urandom));
				repeat (80) send_random();
			end
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		drive_t exp_d;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drive.size() == 0) begin
				$error("unexpected result drive_command=%h", m_tdata);
				fail_count++;
			end else begin
				exp_d = pending_drive.pop_front();
				if (m_tdata !== exp_d.drive) begin
					$error("drive_command expected %h actual %h", exp_d.drive, m_tdata);
					fail_count++;
				end
				if (m_tuser[0] !== exp_d.sat) begin
					$error("saturated expected %b actual %b", exp_d.sat, m_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (coef_a[i]) coef_a[i] = '0;
		foreach (coef_b[i]) coef_b[i] = '0;
		foreach (plant_x[i]) plant_x[i] = '0;
		h_reg = 16'd655;
		n_reg = 4'd1;
		t_reg = 3'd1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_drained_steps();
		test_random_phases();

		wait_drained();
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
rtl/core/gssc_pkg.sv
rtl/core/gssc_mac.sv
rtl/core/gain_scheduled_state_controller_core.sv
verif/gain_scheduled_state_controller_core_tb.sv
